FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands; they compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Hold prop at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Require cons in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: sv/swda_pkg.sv
// ----------------------------------------------------------------------------
// swda_pkg
// Command, status and sequencer state types for the depth-access stack.
// ----------------------------------------------------------------------------
`default_nettype none

package swda_pkg;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int DIDX_W   = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_POPB   = 3'd2,
        CMD_PEEK   = 3'd3,
        CMD_READ   = 3'd4,
        CMD_INSERT = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_BADIDX = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_RD,
        S_WR,
        S_INS,
        S_FIN
    } state_t;

endpackage

`default_nettype wire

FILE: sv/swda_ram.sv
// ----------------------------------------------------------------------------
// swda_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module swda_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/stack_with_depth_access.sv
// Push and every refused command go straight to the finish state; pop, peek and
// read at depth first capture the RAM word in the look state; pop bottom then
// moves each word above the bottom down and insert below depth k moves the words
// above it up, one per read/write pair, before insert writes the new word.
// One command is in work at a time; idle returns as the result loads, and an
// out_ready stall holds the block in finish. Reset clears the count, the sequencer and out_valid.
// ----------------------------------------------------------------------------
// stack_with_depth_access
// Bounded LIFO stack with top/bottom pop, peek, read and insert at depth.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module stack_with_depth_access #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // command channel
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [swda_pkg::CMD_W-1:0]            cmd,
    input  wire logic [DATA_WIDTH-1:0]                 data_in,
    input  wire logic [swda_pkg::DIDX_W-1:0]           depth_index,
    // result channel
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [DATA_WIDTH-1:0]                      data_out,
    output logic [swda_pkg::STATUS_W-1:0]              status,
    output logic [$clog2(DEPTH+1)-1:0]                 count_out
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH+1);
    localparam int CMP_W  = (CNT_W > swda_pkg::DIDX_W) ? CNT_W : swda_pkg::DIDX_W;

    // Sequencer state and working registers
    swda_pkg::state_t  state_reg, state_next;
    swda_pkg::cmd_t    cmd_reg, cmd_next;
    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ADDR_W-1:0] lim_reg, lim_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DATA_WIDTH-1:0] res_data_reg, res_data_next;
    swda_pkg::status_t res_status_reg, res_status_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] data_out_reg, data_out_next;
    swda_pkg::status_t     status_reg, status_next;
    logic [CNT_W-1:0]      count_out_reg, count_out_next;

    // RAM port
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    // Address arithmetic and flags shared between commands
    swda_pkg::cmd_t    cmd_in;
    logic              is_full;
    logic              is_empty;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  depth_ext;
    logic              depth_miss;
    logic [CMP_W-1:0]  depth_addr_wide;
    logic [ADDR_W-1:0] depth_addr;
    logic [ADDR_W-1:0] top_addr;
    logic [CNT_W-1:0]  cnt_inc;
    logic [ADDR_W-1:0] ptr_inc;
    logic [ADDR_W-1:0] ptr_dec;
    logic              out_free;

    // Check terms
    logic              push_take;
    logic              out_err;

    assign cmd_in          = swda_pkg::cmd_t'(cmd);
    assign is_full         = (count_reg == CNT_W'(DEPTH));
    assign is_empty        = (count_reg == '0);
    assign cnt_ext         = CMP_W'(count_reg);
    assign depth_ext       = CMP_W'(depth_index);
    assign depth_miss      = (depth_ext >= cnt_ext);
    assign depth_addr_wide = cnt_ext - CMP_W'(1) - depth_ext;
    assign depth_addr      = depth_addr_wide[ADDR_W-1:0];
    assign top_addr        = ADDR_W'(count_reg - CNT_W'(1));
    assign cnt_inc         = count_reg + CNT_W'(1);
    assign ptr_inc         = ptr_reg + ADDR_W'(1);
    assign ptr_dec         = ptr_reg - ADDR_W'(1);
    assign out_free        = !out_valid_reg || out_ready;

    swda_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH),
        .AW    (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swda_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        data_reg       <= data_next;
        ptr_reg        <= ptr_next;
        lim_reg        <= lim_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        data_out_reg   <= data_out_next;
        status_reg     <= status_next;
        count_out_reg  <= count_out_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        data_next       = data_reg;
        ptr_next        = ptr_reg;
        lim_next        = lim_reg;
        count_next      = count_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        data_out_next   = data_out_reg;
        status_next     = status_reg;
        count_out_next  = count_out_reg;
        in_ready        = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = ptr_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = ptr_reg;

        case (state_reg)
            swda_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next        = cmd_in;
                    data_next       = data_in;
                    res_data_next   = '0;
                    res_status_next = swda_pkg::STAT_OK;
                    state_next      = swda_pkg::S_FIN;
                    case (cmd_in)
                        swda_pkg::CMD_PUSH:
                        begin
                            if (is_full)
                            begin
                                res_status_next = swda_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[ADDR_W-1:0];
                                ram_wdata  = data_in;
                                count_next = cnt_inc;
                            end
                        end
                        swda_pkg::CMD_POP:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = swda_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = top_addr;
                                count_next = count_reg - CNT_W'(1);
                                state_next = swda_pkg::S_LOOK;
                            end
                        end
                        swda_pkg::CMD_POPB:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = swda_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                // read the bottom, then slide the rest down
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                ptr_next   = ADDR_W'(1);
                                lim_next   = top_addr;
                                count_next = count_reg - CNT_W'(1);
                                state_next = swda_pkg::S_LOOK;
                            end
                        end
                        swda_pkg::CMD_PEEK:
                        begin
                            if (is_empty)
                            begin
                                res_status_next = swda_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = top_addr;
                                state_next = swda_pkg::S_LOOK;
                            end
                        end
                        swda_pkg::CMD_READ:
                        begin
                            if (depth_miss)
                            begin
                                res_status_next = swda_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = depth_addr;
                                state_next = swda_pkg::S_LOOK;
                            end
                        end
                        swda_pkg::CMD_INSERT:
                        begin
                            if (is_full)
                            begin
                                res_status_next = swda_pkg::STAT_FULL;
                            end
                            else if (depth_miss)
                            begin
                                res_status_next = swda_pkg::STAT_BADIDX;
                            end
                            else
                            begin
                                // open a slot: move words top-down, one per pair
                                ptr_next   = count_reg[ADDR_W-1:0];
                                lim_next   = depth_addr;
                                count_next = cnt_inc;
                                state_next = swda_pkg::S_RD;
                            end
                        end
                        default:
                        begin
                            res_status_next = swda_pkg::STAT_BADIDX;
                        end
                    endcase
                end
            end
            swda_pkg::S_LOOK:
            begin
                res_data_next = ram_rdata;
                if (cmd_reg == swda_pkg::CMD_POPB && lim_reg != '0)
                begin
                    state_next = swda_pkg::S_RD;
                end
                else
                begin
                    state_next = swda_pkg::S_FIN;
                end
            end
            swda_pkg::S_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = (cmd_reg == swda_pkg::CMD_INSERT) ? ptr_dec : ptr_reg;
                state_next = swda_pkg::S_WR;
            end
            swda_pkg::S_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                if (cmd_reg == swda_pkg::CMD_INSERT)
                begin
                    ram_waddr = ptr_reg;
                    if (ptr_dec == lim_reg)
                    begin
                        state_next = swda_pkg::S_INS;
                    end
                    else
                    begin
                        ptr_next   = ptr_dec;
                        state_next = swda_pkg::S_RD;
                    end
                end
                else
                begin
                    ram_waddr = ptr_dec;
                    if (ptr_reg == lim_reg)
                    begin
                        state_next = swda_pkg::S_FIN;
                    end
                    else
                    begin
                        ptr_next   = ptr_inc;
                        state_next = swda_pkg::S_RD;
                    end
                end
            end
            swda_pkg::S_INS:
            begin
                ram_we     = 1'b1;
                ram_waddr  = lim_reg;
                ram_wdata  = data_reg;
                state_next = swda_pkg::S_FIN;
            end
            swda_pkg::S_FIN:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    data_out_next  = res_data_reg;
                    status_next    = res_status_reg;
                    count_out_next = count_reg;
                    state_next     = swda_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = swda_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign status    = status_reg;
    assign count_out = count_out_reg;

    // Checks
    assign push_take = in_valid && in_ready && cmd_in == swda_pkg::CMD_PUSH && !is_full;
    assign out_err   = out_valid && status != swda_pkg::STAT_OK;

    `ASSERT_AT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH), "count above depth")
    `ASSERT_NEXT(a_push_count, clk, rst_n, push_take, count_reg == $past(cnt_inc), "push count lost")
    `ASSERT_AT(a_err_zero, clk, rst_n, !out_err || data_out == '0, "error data not zero")
    `ASSERT_AT(a_one_port, clk, rst_n, !(ram_we && ram_re), "RAM read and write in one cycle")

endmodule

`default_nettype wire
